FILE: hdl/bbsr_pkg.sv
// Shared constants, codes and types of the bad block skip remap unit.
// No dependencies; the interfaces, the divider and the top unit import this package.
package bbsr_pkg;

    localparam int MAX_BLOCKS   = 4096;
    localparam int SECTOR_WIDTH = 32;

    localparam int MAP_AW     = $clog2(MAX_BLOCKS);
    localparam int MAP_DW     = 16;
    localparam int CNT_W      = 13;
    localparam int SEC_W      = 32;
    localparam int SPB_W      = 13;
    localparam int CAP_W      = 25;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PROD_W     = MAP_DW + SPB_W;
    localparam int CAPP_W     = CNT_W + SPB_W;

    localparam logic [MAP_DW-1:0] SENTINEL_BLOCK = 16'hffff;
    localparam logic [CNT_W-1:0]  MAX_BLOCKS_C   = CNT_W'(MAX_BLOCKS);
    localparam logic [CAP_W-1:0]  CAP_MAX        = {CAP_W{1'b1}};
    localparam logic [SEC_W-1:0]  SECTOR_MASK    = (SECTOR_WIDTH >= SEC_W) ? {SEC_W{1'b1}}
        : SEC_W'((64'd1 << SECTOR_WIDTH) - 64'd1);

    localparam logic [MODE_W-1:0] MODE_SCAN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VERIFY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMAP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REMAP_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SECTORS = 2'd2;

    typedef struct packed {
        logic             start;
        logic [SEC_W-1:0] dividend;
        logic [SPB_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SEC_W-1:0] quotient;
        logic [SPB_W-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: hdl/bbsr_req_if.sv
// Input channel of the bad block skip remap unit: valid, ready and one item.
// Depends on bbsr_pkg for the field widths.
interface bbsr_req_if import bbsr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic              block_is_bad;
    logic              first_of_pass;
    logic              last_of_pass;
    logic [SEC_W-1:0]  logical_sector;

    modport source (output valid, mode, block_is_bad, first_of_pass, last_of_pass,
                    logical_sector, input ready);
    modport sink   (input valid, mode, block_is_bad, first_of_pass, last_of_pass,
                    logical_sector, output ready);
endinterface

FILE: hdl/bbsr_rsp_if.sv
// Result channel of the bad block skip remap unit: valid, ready and one result.
// Depends on bbsr_pkg for the field widths.
interface bbsr_rsp_if import bbsr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SEC_W-1:0] physical_sector;
    logic             unmapped;
    logic             mismatch;
    logic [CNT_W-1:0] good_block_count;
    logic [CAP_W-1:0] capacity_sectors;

    modport source (output valid, physical_sector, unmapped, mismatch, good_block_count,
                    capacity_sectors, input ready);
    modport sink   (input valid, physical_sector, unmapped, mismatch, good_block_count,
                    capacity_sectors, output ready);
endinterface

FILE: hdl/bbsr_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
// Depends on bbsr_pkg for the field widths.
interface bbsr_cfg_if import bbsr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/bbsr_map_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; holds the logical-to-physical block map.
module bbsr_map_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: hdl/bbsr_divider.sv
// Restoring divider, one quotient bit per cycle, for sector / block size.
// Depends on bbsr_pkg for widths and the request and response structs.
module bbsr_divider import bbsr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int STEP_W = $clog2(SEC_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SEC_W-1:0]  quot_reg, quot_next;
    logic [SPB_W-1:0]  rem_reg, rem_next;
    logic [SPB_W-1:0]  div_reg, div_next;
    logic [SPB_W:0]    trial;
    logic              fits;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        // The partial remainder stays below the divisor, so the shifted trial
        // value is below twice the divisor and one subtract settles the bit.
        trial     = {rem_reg, quot_reg[SEC_W-1]};
        fits      = (trial >= {1'b0, div_reg});
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quot_next = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[SEC_W-2:0], fits};
            rem_next  = fits ? SPB_W'(trial - {1'b0, div_reg}) : trial[SPB_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SEC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;
endmodule

FILE: hdl/bad_block_skip_remap_unit.sv
// Bad block skip remap unit: builds, verifies and applies a block map in RAM.
// Depends on bbsr_pkg, the channel interfaces, bbsr_map_ram and bbsr_divider.
// States: scan SCAN_WR, CAP, DONE; verify VER_RD, VER_CMP, CAP, DONE; remap DIV (32-step
// divider), MAP_RD, MUL, ADD, CAP, DONE; untranslated CAP, DONE. One item at a time.
// Reset clears counters and flags at once; the map RAM needs no clearing pass.
// The result register lets the next item be accepted while a result waits.
module bad_block_skip_remap_unit import bbsr_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    bbsr_cfg_if.sink  cfg,
    bbsr_req_if.sink  req,
    bbsr_rsp_if.source rsp
);
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SCAN_WR = 4'd1;
    localparam logic [3:0] ST_VER_RD  = 4'd2;
    localparam logic [3:0] ST_VER_CMP = 4'd3;
    localparam logic [3:0] ST_DIV     = 4'd4;
    localparam logic [3:0] ST_MAP_RD  = 4'd5;
    localparam logic [3:0] ST_MUL     = 4'd6;
    localparam logic [3:0] ST_ADD     = 4'd7;
    localparam logic [3:0] ST_CAP     = 4'd8;
    localparam logic [3:0] ST_DONE    = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic              en_reg, en_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [SPB_W-1:0]  spb_reg, spb_next;
    logic [CNT_W-1:0]  gc_reg, gc_next;
    logic [CNT_W-1:0]  vg_reg, vg_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              mism_reg, mism_next;
    logic              out_valid_reg, out_valid_next;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              bad_reg, bad_next;
    logic              last_reg, last_next;
    logic [SEC_W-1:0]  phys_reg, phys_next;
    logic              unm_reg, unm_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [CAPP_W-1:0] capp_reg, capp_next;
    logic [SEC_W-1:0]  out_phys_reg, out_phys_next;
    logic              out_unm_reg, out_unm_next;
    logic              out_mism_reg, out_mism_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [CAP_W-1:0]  out_cap_reg, out_cap_next;

    logic              accept;
    logic [CNT_W-1:0]  limit;
    logic              in_range;
    logic [CNT_W-1:0]  vg_upd;
    logic [CNT_W-1:0]  blocks;
    logic [MAP_DW-1:0] pb;

    logic              wr_en;
    logic [MAP_AW-1:0] wr_addr;
    logic [MAP_DW-1:0] wr_data;
    logic              rd_en;
    logic [MAP_AW-1:0] rd_addr;
    logic [MAP_DW-1:0] rd_data;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    bbsr_map_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (MAP_DW)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bbsr_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && (state_reg == ST_IDLE);

    assign limit    = (total_reg > MAX_BLOCKS_C) ? MAX_BLOCKS_C : total_reg;
    assign in_range = (idx_reg < limit);
    assign blocks   = en_reg ? gc_reg : total_reg;

    // The divider starts on the accepting edge straight from the channel.
    assign div_req.start    = accept && (req.mode == MODE_REMAP) && en_reg
                              && (spb_reg != '0);
    assign div_req.dividend = req.logical_sector & SECTOR_MASK;
    assign div_req.divisor  = spb_reg;

    always_comb
    begin
        wr_en   = (state_reg == ST_SCAN_WR) && in_range && !bad_reg
                  && (gc_reg < MAX_BLOCKS_C);
        wr_addr = gc_reg[MAP_AW-1:0];
        wr_data = MAP_DW'(idx_reg[MAP_AW-1:0]);
        rd_en   = (state_reg == ST_VER_RD) || (state_reg == ST_MAP_RD);
        rd_addr = (state_reg == ST_VER_RD) ? vg_reg[MAP_AW-1:0]
                                           : div_rsp.quotient[MAP_AW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        en_next        = en_reg;
        total_next     = total_reg;
        spb_next       = spb_reg;
        gc_next        = gc_reg;
        vg_next        = vg_reg;
        idx_next       = idx_reg;
        mism_next      = mism_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mode_next      = mode_reg;
        bad_next       = bad_reg;
        last_next      = last_reg;
        phys_next      = phys_reg;
        unm_next       = unm_reg;
        prod_next      = prod_reg;
        capp_next      = capp_reg;
        out_phys_next  = out_phys_reg;
        out_unm_next   = out_unm_reg;
        out_mism_next  = out_mism_reg;
        out_cnt_next   = out_cnt_reg;
        out_cap_next   = out_cap_reg;
        vg_upd         = vg_reg;
        pb             = SENTINEL_BLOCK;

        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_REMAP_ENABLE:  en_next    = cfg.data[0];
                CFG_TOTAL_BLOCKS:  total_next = cfg.data;
                CFG_BLOCK_SECTORS: spb_next   = cfg.data;
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = req.mode;
                    bad_next  = req.block_is_bad;
                    last_next = req.last_of_pass;
                    phys_next = '0;
                    unm_next  = 1'b0;
                    case (req.mode)
                        MODE_SCAN:
                        begin
                            if (req.first_of_pass)
                            begin
                                gc_next   = '0;
                                idx_next  = '0;
                                mism_next = 1'b0;
                            end
                            state_next = ST_SCAN_WR;
                        end
                        MODE_VERIFY:
                        begin
                            if (req.first_of_pass)
                            begin
                                vg_next   = '0;
                                idx_next  = '0;
                                mism_next = 1'b0;
                            end
                            state_next = ST_VER_RD;
                        end
                        MODE_REMAP:
                        begin
                            if (div_req.start)
                            begin
                                state_next = ST_DIV;
                            end
                            else
                            begin
                                phys_next  = req.logical_sector & SECTOR_MASK;
                                state_next = ST_CAP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_CAP;
                        end
                    endcase
                end
            end
            ST_SCAN_WR:
            begin
                if (wr_en)
                begin
                    gc_next = gc_reg + 1'b1;
                end
                if (in_range)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                state_next = ST_CAP;
            end
            ST_VER_RD:
            begin
                state_next = ST_VER_CMP;
            end
            ST_VER_CMP:
            begin
                if (in_range && !bad_reg && (vg_reg < MAX_BLOCKS_C))
                begin
                    if ((vg_reg >= gc_reg) || (rd_data != MAP_DW'(idx_reg[MAP_AW-1:0])))
                    begin
                        mism_next = 1'b1;
                    end
                    vg_upd = vg_reg + 1'b1;
                end
                if (in_range)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                // End of pass: a different number of good blocks is a change too.
                if (last_reg && (vg_upd != gc_reg))
                begin
                    mism_next = 1'b1;
                end
                vg_next    = vg_upd;
                state_next = ST_CAP;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_MAP_RD;
                end
            end
            ST_MAP_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (div_rsp.quotient < SEC_W'(gc_reg))
                begin
                    pb = rd_data;
                end
                else
                begin
                    unm_next = 1'b1;
                end
                prod_next  = PROD_W'(pb) * PROD_W'(spb_reg);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                phys_next  = (SEC_W'(prod_reg) + SEC_W'(div_rsp.remainder)) & SECTOR_MASK;
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                capp_next  = CAPP_W'(blocks) * CAPP_W'(spb_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_phys_next  = phys_reg;
                    out_unm_next   = unm_reg;
                    out_mism_next  = mism_reg;
                    out_cnt_next   = (mode_reg == MODE_VERIFY) ? vg_reg : gc_reg;
                    out_cap_next   = (capp_reg > CAPP_W'(CAP_MAX)) ? CAP_MAX
                                                                   : capp_reg[CAP_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            en_reg        <= 1'b0;
            total_reg     <= CNT_W'(1024);
            spb_reg       <= SPB_W'(256);
            gc_reg        <= '0;
            vg_reg        <= '0;
            idx_reg       <= '0;
            mism_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            en_reg        <= en_next;
            total_reg     <= total_next;
            spb_reg       <= spb_next;
            gc_reg        <= gc_next;
            vg_reg        <= vg_next;
            idx_reg       <= idx_next;
            mism_reg      <= mism_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        bad_reg      <= bad_next;
        last_reg     <= last_next;
        phys_reg     <= phys_next;
        unm_reg      <= unm_next;
        prod_reg     <= prod_next;
        capp_reg     <= capp_next;
        out_phys_reg <= out_phys_next;
        out_unm_reg  <= out_unm_next;
        out_mism_reg <= out_mism_next;
        out_cnt_reg  <= out_cnt_next;
        out_cap_reg  <= out_cap_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.physical_sector  = out_phys_reg;
    assign rsp.unmapped         = out_unm_reg;
    assign rsp.mismatch         = out_mism_reg;
    assign rsp.good_block_count = out_cnt_reg;
    assign rsp.capacity_sectors = out_cap_reg;
endmodule
